>>> sv/ipv4_tcp_checksum_engine_assert.svh
// ----------------------------------------------------------------------------
// IPv4/TCP checksum engine assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef IPV4_TCP_CHECKSUM_ENGINE_ASSERT_SVH
`define IPV4_TCP_CHECKSUM_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, ante, cons)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> sv/ipv4ck_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum engine package
// Shared constants, transaction structs and ones-complement helpers.
// ----------------------------------------------------------------------------
package ipv4ck_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;

    localparam logic [15:0] OFS_PROTO    = 16'd9;
    localparam logic [15:0] OFS_IPCK_HI  = 16'd10;
    localparam logic [15:0] OFS_IPCK_LO  = 16'd11;
    localparam logic [15:0] OFS_SRC      = 16'd12;
    localparam logic [15:0] OFS_DST      = 16'd16;
    localparam logic [15:0] OFS_HDR_END  = 16'd20;
    localparam logic [15:0] OFS_TCPCK_HI = 16'd16;
    localparam logic [15:0] OFS_TCPCK_LO = 16'd17;
    localparam logic [3:0]  MIN_IHL      = 4'd5;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [15:0] SUM_ONES     = 16'hFFFF;

    // completed packet, handed from the accumulator to the finalize stages
    typedef struct packed {
        logic [15:0] hdr_sum;
        logic [15:0] seg_sum;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] seg_len;
        logic [15:0] ip_stored;
        logic [15:0] tcp_stored;
        logic [7:0]  protocol;
        logic        malformed;
    } snap_t;

    typedef struct packed {
        logic        ip_header_ok;
        logic        is_tcp;
        logic        tcp_sum_ok;
        logic        packet_ok;
        logic        malformed;
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
    } res_t;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

    // fold a wide integer sum of up to eight words into 0..0xffff
    function automatic logic [15:0] fold19(input logic [18:0] x);
        logic [16:0] a;
        begin
            a = {1'b0, x[15:0]} + {14'd0, x[18:16]};
            return a[15:0] + {15'd0, a[16]};
        end
    endfunction

endpackage

>>> sv/ipv4ck_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum accumulator
// Per-byte header/segment sums and field capture; snapshot on last byte.
// ----------------------------------------------------------------------------
module ipv4ck_accum
    import ipv4ck_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        snap_ready,
    output logic        snap_valid,
    output snap_t       snap
);

    localparam logic [16:0] MAX_LIMIT = 17'(MAX_PACKET_BYTES);

    logic [15:0] count_reg, count_next;
    logic        too_long_reg, too_long_next;
    logic [3:0]  hwords_reg, hwords_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] hsum_reg, hsum_next;
    logic [15:0] ssum_reg, ssum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [15:0] ipck_reg, ipck_next;
    logic [15:0] tcpck_reg, tcpck_next;
    logic        snap_valid_reg;
    snap_t       snap_reg, snap_next;

    logic        s_ready;
    logic        accept;
    logic [15:0] idx;
    logic [15:0] hlen;
    logic        in_hdr;
    logic        tck_hi;
    logic        tck_lo;
    logic        excl;
    logic [7:0]  kept;
    logic [15:0] word;

    assign s_ready    = !snap_valid_reg || snap_ready;
    assign in_stall   = !s_ready;
    assign accept     = in_valid && s_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb
    begin
        idx         = count_reg;
        hwords_next = (idx == 16'd0) ? data_byte[3:0] : hwords_reg;
        hlen        = {10'd0, hwords_next, 2'b00};
        in_hdr      = idx < hlen;
        tck_hi      = idx == (hlen + OFS_TCPCK_HI);
        tck_lo      = idx == (hlen + OFS_TCPCK_LO);
        excl        = in_hdr ? (idx == OFS_IPCK_HI || idx == OFS_IPCK_LO) : (tck_hi || tck_lo);
        kept        = excl ? 8'd0 : data_byte;
        word        = idx[0] ? {pend_reg, kept} : {kept, 8'd0};

        count_next    = count_reg;
        too_long_next = too_long_reg;
        proto_next    = proto_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        hsum_next     = hsum_reg;
        ssum_next     = ssum_reg;
        pend_next     = pend_reg;
        ipck_next     = ipck_reg;
        tcpck_next    = tcpck_reg;

        if (!too_long_reg)
        begin
            if ({1'b0, idx} >= MAX_LIMIT)
            begin
                too_long_next = 1'b1;
            end
            else
            begin
                if (idx == OFS_PROTO)
                begin
                    proto_next = data_byte;
                end
                if (idx == OFS_IPCK_HI)
                begin
                    ipck_next = {data_byte, ipck_reg[7:0]};
                end
                if (idx == OFS_IPCK_LO)
                begin
                    ipck_next = {ipck_reg[15:8], data_byte};
                end
                if (idx >= OFS_SRC && idx < OFS_DST)
                begin
                    src_next = {src_reg[23:0], data_byte};
                end
                if (idx >= OFS_DST && idx < OFS_HDR_END)
                begin
                    dst_next = {dst_reg[23:0], data_byte};
                end
                if (!in_hdr && tck_hi)
                begin
                    tcpck_next = {data_byte, tcpck_reg[7:0]};
                end
                if (!in_hdr && tck_lo)
                begin
                    tcpck_next = {tcpck_reg[15:8], data_byte};
                end
                if (!idx[0])
                begin
                    pend_next = kept;
                end
                if (idx[0] || last_byte)
                begin
                    if (in_hdr)
                    begin
                        hsum_next = oc_add(hsum_reg, word);
                    end
                    else
                    begin
                        ssum_next = oc_add(ssum_reg, word);
                    end
                end
                count_next = idx + 16'd1;
            end
        end

        snap_next.hdr_sum    = hsum_next;
        snap_next.seg_sum    = ssum_next;
        snap_next.src_addr   = src_next;
        snap_next.dst_addr   = dst_next;
        snap_next.seg_len    = count_next - hlen;
        snap_next.ip_stored  = ipck_next;
        snap_next.tcp_stored = tcpck_next;
        snap_next.protocol   = proto_next;
        snap_next.malformed  = (hwords_next < MIN_IHL) || too_long_next || (count_next < hlen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            too_long_reg   <= 1'b0;
            hwords_reg     <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            hsum_reg       <= '0;
            ssum_reg       <= '0;
            pend_reg       <= '0;
            ipck_reg       <= '0;
            tcpck_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && last_byte)
            begin
                count_reg      <= '0;
                too_long_reg   <= 1'b0;
                hwords_reg     <= '0;
                proto_reg      <= '0;
                src_reg        <= '0;
                dst_reg        <= '0;
                hsum_reg       <= '0;
                ssum_reg       <= '0;
                pend_reg       <= '0;
                ipck_reg       <= '0;
                tcpck_reg      <= '0;
                snap_valid_reg <= 1'b1;
            end
            else
            begin
                if (accept)
                begin
                    count_reg    <= count_next;
                    too_long_reg <= too_long_next;
                    hwords_reg   <= hwords_next;
                    proto_reg    <= proto_next;
                    src_reg      <= src_next;
                    dst_reg      <= dst_next;
                    hsum_reg     <= hsum_next;
                    ssum_reg     <= ssum_next;
                    pend_reg     <= pend_next;
                    ipck_reg     <= ipck_next;
                    tcpck_reg    <= tcpck_next;
                end
                if (snap_ready)
                begin
                    snap_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            snap_reg <= snap_next;
        end
    end

endmodule

>>> sv/ipv4ck_finalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4/TCP checksum finalize
// Pseudo-header sum, fold, verify compares and the output register.
// ----------------------------------------------------------------------------
module ipv4ck_finalize
    import ipv4ck_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  snap_valid,
    input  snap_t snap,
    output logic  snap_ready,
    output logic  out_valid,
    input  logic  out_stall,
    output res_t  res
);

    logic        f1_valid_reg;
    logic [18:0] psum_reg;
    logic [18:0] pchk_reg;
    logic        ipok_reg;
    logic        tcp_reg;
    logic        mal_reg;
    logic [15:0] ipck_reg;
    logic        out_valid_reg;
    res_t        res_reg;

    logic        out_free;
    logic        f1_ready;
    logic [18:0] psum_next;
    logic [18:0] pchk_next;
    logic [15:0] t_fold;
    logic [15:0] c_fold;
    res_t        res_next;

    assign out_free   = !out_valid_reg || !out_stall;
    assign f1_ready   = !f1_valid_reg || out_free;
    assign snap_ready = f1_ready;
    assign out_valid  = out_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        psum_next = {3'd0, snap.src_addr[31:16]} + {3'd0, snap.src_addr[15:0]}
                  + {3'd0, snap.dst_addr[31:16]} + {3'd0, snap.dst_addr[15:0]}
                  + {11'd0, PROTO_TCP} + {3'd0, snap.seg_len} + {3'd0, snap.seg_sum};
        pchk_next = psum_next + {3'd0, snap.tcp_stored};

        t_fold = fold19(psum_reg);
        c_fold = fold19(pchk_reg);

        res_next.ip_header_ok = ipok_reg;
        res_next.is_tcp       = tcp_reg;
        res_next.tcp_sum_ok   = c_fold == SUM_ONES;
        res_next.packet_ok    = ipok_reg && tcp_reg && (c_fold == SUM_ONES) && !mal_reg;
        res_next.malformed    = mal_reg;
        res_next.ip_checksum  = ipck_reg;
        res_next.tcp_checksum = ~t_fold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_ready)
            begin
                f1_valid_reg <= snap_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_ready && snap_valid)
        begin
            psum_reg <= psum_next;
            pchk_reg <= pchk_next;
            ipok_reg <= oc_add(snap.hdr_sum, snap.ip_stored) == SUM_ONES;
            tcp_reg  <= snap.protocol == PROTO_TCP;
            mal_reg  <= snap.malformed;
            ipck_reg <= ~snap.hdr_sum;
        end
        if (out_free && f1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

endmodule

>>> sv/ipv4_tcp_checksum_engine.sv
`timescale 1ns / 1ps
// Each packet's result passes the snapshot, finalize and output registers after its last byte is accepted.
// Throughput: one byte per cycle while in_stall is low; each 16-bit word is summed with an end-around add.
// in_stall rises only when the snapshot, finalize and output registers all hold packets and out_stall is high.
// Reset: asynchronous, active low; clears the sums, counters and all valid flags.
// ----------------------------------------------------------------------------
// IPv4/TCP checksum engine
// Streams one IPv4/TCP packet per transaction sequence and reports checksums.
// ----------------------------------------------------------------------------
`include "ipv4_tcp_checksum_engine_assert.svh"

module ipv4_tcp_checksum_engine
    import ipv4ck_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ip_header_ok,
    output logic        is_tcp,
    output logic        tcp_sum_ok,
    output logic        packet_ok,
    output logic        malformed,
    output logic [15:0] ip_checksum,
    output logic [15:0] tcp_checksum
);

    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;
    res_t  res;

    ipv4ck_accum #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .snap_ready (snap_ready),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    ipv4ck_finalize u_finalize (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res        (res)
    );

    assign ip_header_ok = res.ip_header_ok;
    assign is_tcp       = res.is_tcp;
    assign tcp_sum_ok   = res.tcp_sum_ok;
    assign packet_ok    = res.packet_ok;
    assign malformed    = res.malformed;
    assign ip_checksum  = res.ip_checksum;
    assign tcp_checksum = res.tcp_checksum;

    `ASSERT_NEXT(a_last_snaps, in_valid && !in_stall && last_byte, snap_valid)
    `ASSERT_SAME(a_stall_full, in_stall, snap_valid && out_valid && out_stall)
    `ASSERT_SAME(a_pkt_ok, out_valid && packet_ok, ip_header_ok && is_tcp && tcp_sum_ok && !malformed)

endmodule
